[rtl/core/pufwrl_pkg.sv]
package pufwrl_pkg;

  localparam int UID_W = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W = 8;
  localparam int OC_W = 3;
  localparam int SLOT_OUT_W = 6;

  localparam logic [OC_W-1:0] OC_COUNTED = 3'd0;
  localparam logic [OC_W-1:0] OC_RESTART = 3'd1;
  localparam logic [OC_W-1:0] OC_CLAIMED = 3'd2;
  localparam logic [OC_W-1:0] OC_FULL = 3'd3;
  localparam logic [OC_W-1:0] OC_LIMITED = 3'd4;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd60000;
  localparam logic [CNT_W-1:0] MAX_RESET = 8'd10;
  localparam logic [CNT_W-1:0] CNT_SAT = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_ONE = 8'd1;

  typedef struct packed {
    logic [TIME_W-1:0] window;
    logic [CNT_W-1:0] max_req;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic [UID_W-1:0] uid;
    logic [TIME_W-1:0] now;
    logic hit;
    logic empty_seen;
    logic allowed;
    logic [OC_W-1:0] outcome;
    logic [CNT_W-1:0] count;
  } token_t;

  typedef struct packed {
    logic en;
    logic [UID_W-1:0] uid;
    logic [TIME_W-1:0] now;
  } claim_t;

endpackage

[rtl/core/per_user_fixed_window_rate_limiter.sv]
// channel   direction  handshake                 payload
// request   in         in_valid_i / in_stall_o   user_id_i, now_ms_i
// result    out        out_valid_o / out_stall_i allowed_o, outcome_o, slot_index_o,
//                                                count_after_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A request walks the cell chain, one register per slot cell, entering the first cell
// on the accept edge; it is then collected at the chain end, and a last step, held while
// a stalled result is still waiting, writes back a claimed slot and registers the result.
// One request is in flight at a time; in_stall_o is high from accept until the
// result is registered. Reset empties every slot at once.
// A stalled result holds in the output register; a finished request waits for it.
module per_user_fixed_window_rate_limiter import pufwrl_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [TIME_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [UID_W-1:0]      user_id_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  allowed_o,
  output logic [OC_W-1:0]       outcome_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic [CNT_W-1:0]      count_after_o
);

  localparam int IW = $clog2(SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  cfg_t cfg_q;
  token_t tok_head;
  token_t tok [SLOTS+1];
  logic [IW-1:0] hit_idx [SLOTS+1];
  logic [IW-1:0] empty_idx [SLOTS+1];
  logic [SLOTS-1:0] tok_valid;

  token_t fin_q;
  logic [IW-1:0] fin_hit_idx_q;
  logic [IW-1:0] fin_empty_idx_q;

  claim_t claim;
  logic in_acc;
  logic out_free;
  logic finish;

  logic out_valid_q;
  logic allowed_q, allowed_d;
  logic [OC_W-1:0] outcome_q, outcome_d;
  logic [IW-1:0] slot_d;
  logic [IW+SLOT_OUT_W-1:0] slot_wide;
  logic [SLOT_OUT_W-1:0] slot_q;
  logic [CNT_W-1:0] count_q, count_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window <= WINDOW_RESET;
      cfg_q.max_req <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: cfg_q.window <= cfg_data_i;
        CFG_MAX: cfg_q.max_req <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tok_head = '0;
    tok_head.valid = in_acc;
    tok_head.uid = user_id_i;
    tok_head.now = now_ms_i;
    tok_head.allowed = 1'b1;
    tok_head.outcome = OC_FULL;
  end
  assign tok[0] = tok_head;
  assign hit_idx[0] = IW'(SLOTS);
  assign empty_idx[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    pufwrl_cell #(
      .IW (IW),
      .IDX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cfg_i      (cfg_q),
      .claim_i    (claim),
      .claim_idx_i(fin_empty_idx_q),
      .tok_i      (tok[k]),
      .hit_idx_i  (hit_idx[k]),
      .empty_idx_i(empty_idx[k]),
      .tok_o      (tok[k+1]),
      .hit_idx_o  (hit_idx[k+1]),
      .empty_idx_o(empty_idx[k+1])
    );
    assign tok_valid[k] = tok[k+1].valid;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN: if (tok[SLOTS].valid) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && tok[SLOTS].valid) begin
      fin_q <= tok[SLOTS];
      fin_hit_idx_q <= hit_idx[SLOTS];
      fin_empty_idx_q <= empty_idx[SLOTS];
    end
  end

  always_comb begin
    claim.en = finish && !fin_q.hit && fin_q.empty_seen;
    claim.uid = fin_q.uid;
    claim.now = fin_q.now;
  end

  always_comb begin
    allowed_d = fin_q.allowed;
    outcome_d = fin_q.outcome;
    slot_d = fin_hit_idx_q;
    count_d = fin_q.count;
    if (!fin_q.hit) begin
      allowed_d = 1'b1;
      if (fin_q.empty_seen) begin
        outcome_d = OC_CLAIMED;
        slot_d = fin_empty_idx_q;
        count_d = CNT_ONE;
      end else begin
        outcome_d = OC_FULL;
        slot_d = IW'(SLOTS);
        count_d = '0;
      end
    end
  end

  assign slot_wide = {{SLOT_OUT_W{1'b0}}, slot_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      allowed_q <= allowed_d;
      outcome_q <= outcome_d;
      slot_q <= slot_wide[SLOT_OUT_W-1:0];
      count_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign allowed_o = allowed_q;
  assign outcome_o = outcome_q;
  assign slot_index_o = slot_q;
  assign count_after_o = count_q;

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_RUN)
    else $error("accepted request did not start the chain walk");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) <= 1)
    else $error("more than one request in the cell chain");

  a_token_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[SLOTS].valid |-> state_q == ST_RUN)
    else $error("request left the chain outside the walk");

  a_refused_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !allowed_o |-> outcome_o == OC_LIMITED)
    else $error("refused result without limited outcome");

  a_full_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OC_FULL |-> count_after_o == '0 && allowed_o)
    else $error("table full result carries a count or a refusal");

endmodule

[rtl/core/pufwrl_cell.sv]
module pufwrl_cell import pufwrl_pkg::*; #(
  parameter int IW = 6,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  claim_t        claim_i,
  input  logic [IW-1:0] claim_idx_i,
  input  token_t        tok_i,
  input  logic [IW-1:0] hit_idx_i,
  input  logic [IW-1:0] empty_idx_i,
  output token_t        tok_o,
  output logic [IW-1:0] hit_idx_o,
  output logic [IW-1:0] empty_idx_o
);

  logic [UID_W-1:0] user_q, user_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [TIME_W-1:0] start_q, start_d;
  token_t tok_q, tok_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [IW-1:0] empty_idx_q, empty_idx_d;

  logic match;
  logic empty;
  logic [TIME_W-1:0] elapsed;
  logic in_win;
  logic [CNT_W-1:0] cnt_inc;
  logic limited;

  assign match = tok_i.valid && !tok_i.hit && (user_q == tok_i.uid);
  assign empty = tok_i.valid && !tok_i.empty_seen && (user_q == '0);
  assign elapsed = tok_i.now - start_q;
  assign in_win = elapsed < cfg_i.window;
  assign cnt_inc = (count_q == CNT_SAT) ? count_q : count_q + CNT_ONE;
  assign limited = cnt_inc > cfg_i.max_req;

  always_comb begin
    user_d = user_q;
    count_d = count_q;
    start_d = start_q;
    tok_d = tok_i;
    hit_idx_d = hit_idx_i;
    empty_idx_d = empty_idx_i;
    if (match) begin
      tok_d.hit = 1'b1;
      hit_idx_d = IW'(IDX);
      if (in_win) begin
        count_d = cnt_inc;
        tok_d.count = cnt_inc;
        tok_d.allowed = !limited;
        tok_d.outcome = limited ? OC_LIMITED : OC_COUNTED;
      end else begin
        count_d = CNT_ONE;
        start_d = tok_i.now;
        tok_d.count = CNT_ONE;
        tok_d.allowed = 1'b1;
        tok_d.outcome = OC_RESTART;
      end
    end
    if (empty) begin
      tok_d.empty_seen = 1'b1;
      empty_idx_d = IW'(IDX);
    end
    if (claim_i.en && (claim_idx_i == IW'(IDX))) begin
      user_d = claim_i.uid;
      count_d = CNT_ONE;
      start_d = claim_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_q <= '0;
      count_q <= '0;
      start_q <= '0;
      tok_q <= '0;
    end else begin
      user_q <= user_d;
      count_q <= count_d;
      start_q <= start_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
  end

  assign tok_o = tok_q;
  assign hit_idx_o = hit_idx_q;
  assign empty_idx_o = empty_idx_q;

endmodule

[verif/rate_limit_checker.sv]
module rate_limit_checker import pufwrl_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [TIME_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [UID_W-1:0]      user_id_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  allowed_i,
  input  logic [OC_W-1:0]       outcome_i,
  input  logic [SLOT_OUT_W-1:0] slot_index_i,
  input  logic [CNT_W-1:0]      count_after_i,
  output int                    mismatch_o,
  output int                    pending_o
);

  typedef struct packed {
    logic                  allowed;
    logic [OC_W-1:0]       outcome;
    logic [SLOT_OUT_W-1:0] slot;
    logic [CNT_W-1:0]      count;
  } decision_t;

  logic [UID_W-1:0]  slot_owner [SLOTS];
  logic [CNT_W-1:0]  slot_hits  [SLOTS];
  logic [TIME_W-1:0] slot_since [SLOTS];
  logic [TIME_W-1:0] window_len;
  logic [CNT_W-1:0]  max_req;
  decision_t         decisions_due [$];
  int                misses;

  function automatic decision_t rate_decide(logic [UID_W-1:0] uid, logic [TIME_W-1:0] now);
    decision_t         d;
    int                found;
    logic [TIME_W-1:0] elapsed;
    d.allowed = 1'b1;
    d.outcome = OC_FULL;
    d.slot    = SLOT_OUT_W'(SLOTS);
    d.count   = '0;
    found     = -1;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (slot_owner[k] == uid) found = k;
    end
    if (found >= 0) begin
      d.slot  = SLOT_OUT_W'(found);
      elapsed = now - slot_since[found];
      if (elapsed < window_len) begin
        if (slot_hits[found] != CNT_SAT) slot_hits[found] = slot_hits[found] + CNT_ONE;
        if (slot_hits[found] > max_req) begin
          d.allowed = 1'b0;
          d.outcome = OC_LIMITED;
        end else begin
          d.outcome = OC_COUNTED;
        end
      end else begin
        slot_hits[found]  = CNT_ONE;
        slot_since[found] = now;
        d.outcome         = OC_RESTART;
      end
      d.count = slot_hits[found];
    end else begin
      for (int k = SLOTS - 1; k >= 0; k--) begin
        if (slot_owner[k] == '0) found = k;
      end
      if (found >= 0) begin
        slot_owner[found] = uid;
        slot_hits[found]  = CNT_ONE;
        slot_since[found] = now;
        d.slot            = SLOT_OUT_W'(found);
        d.outcome         = OC_CLAIMED;
        d.count           = CNT_ONE;
      end
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t want;
    decision_t seen;
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_owner[k] = '0;
        slot_hits[k]  = '0;
        slot_since[k] = '0;
      end
      window_len = WINDOW_RESET;
      max_req    = MAX_RESET;
      misses     = 0;
      decisions_due.delete();
      mismatch_o <= 0;
      pending_o  <= 0;
    end else begin
      seen = {allowed_i, outcome_i, slot_index_i, count_after_i};
      if (out_valid_i && !out_stall_i) begin
        if (decisions_due.size() == 0) begin
          misses++;
          $display("%0t: result with no request outstanding: allowed=%0d outcome=%0d",
                   $time, seen.allowed, seen.outcome, " slot=%0d count=%0d",
                   seen.slot, seen.count);
        end else begin
          want = decisions_due.pop_front();
          if (seen !== want) begin
            misses++;
            $display("%0t: mismatch: expected allowed=%0d outcome=%0d slot=%0d count=%0d",
                     $time, want.allowed, want.outcome, want.slot, want.count);
            $display("%0t:           actual allowed=%0d outcome=%0d slot=%0d count=%0d",
                     $time, seen.allowed, seen.outcome, seen.slot, seen.count);
          end
        end
      end
      if (in_valid_i && !in_stall_i) decisions_due.push_back(rate_decide(user_id_i, now_ms_i));
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WINDOW) window_len = cfg_data_i;
        else max_req = cfg_data_i[CNT_W-1:0];
      end
      mismatch_o <= misses;
      pending_o  <= decisions_due.size();
    end
  end

endmodule

[verif/per_user_fixed_window_rate_limiter_tb.sv]
module per_user_fixed_window_rate_limiter_tb;
  import pufwrl_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_idx_i = CFG_WINDOW;
  logic [TIME_W-1:0]     cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [UID_W-1:0]      user_id_i = '0;
  logic [TIME_W-1:0]     now_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  allowed_o;
  logic [OC_W-1:0]       outcome_o;
  logic [SLOT_OUT_W-1:0] slot_index_o;
  logic [CNT_W-1:0]      count_after_o;

  int                    mismatches;
  int                    pending;
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int                    quiet_cycles = 0;
  int                    sent = 0;
  int                    settings = 0;
  logic [TIME_W-1:0]     clock_ms = '0;
  logic [UID_W-1:0]      crowd [48];

  per_user_fixed_window_rate_limiter #(.SLOTS(32)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .user_id_i, .now_ms_i,
    .out_valid_o, .out_stall_i, .allowed_o, .outcome_o, .slot_index_o, .count_after_o
  );

  rate_limit_checker #(.SLOTS(32)) watch (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .user_id_i, .now_ms_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .allowed_i(allowed_o), .outcome_i(outcome_o), .slot_index_i(slot_index_o),
    .count_after_i(count_after_o),
    .mismatch_o(mismatches), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic submit(logic [UID_W-1:0] uid, logic [TIME_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    user_id_i  <= uid;
    now_ms_i   <= now;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_limits(logic [TIME_W-1:0] window, logic [CNT_W-1:0] max_req);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WINDOW;
    cfg_data_i <= window;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX;
    cfg_data_i <= {24'($urandom()), max_req};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings++;
  endtask

  task automatic set_pace(int regime);
    case (regime)
      0: begin
        idle_pct  = 29;
        stall_pct = 63;
      end
      1: begin
        idle_pct  = 63;
        stall_pct = 29;
      end
      default: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic run_phase(logic [TIME_W-1:0] window, logic [CNT_W-1:0] max_req, int users,
                           int count, int step_max, int regime);
    logic [UID_W-1:0] uid;
    set_pace(regime);
    drain();
    load_limits(window, max_req);
    for (int k = 0; k < users; k++) begin
      crowd[k] = $urandom();
      if (crowd[k] == '0) crowd[k] = 'd1;
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(step_max);
      uid = ($urandom_range(11) == 0) ? '0 : crowd[$urandom_range(users - 1)];
      submit(uid, clock_ms);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_pace(0);

    load_limits(32'd100, 8'd2);
    submit(32'hFFFF_FFFF, 32'd0);
    submit(32'hFFFF_FFFF, 32'd50);
    submit(32'hFFFF_FFFF, 32'd99);
    submit(32'hFFFF_FFFF, 32'd100);
    submit(32'd0, 32'd5);
    submit(32'd0, 32'hFFFF_FFFF);
    submit(32'd0, 32'd10);
    submit(32'd1, 32'h8000_0000);
    submit(32'd0, 32'h8000_0000);
    drain();
    load_limits(32'd0, 8'd255);
    submit(32'hFFFF_FFFF, 32'd100);
    submit(32'd1, 32'h8000_0000);
    drain();
    load_limits(32'hFFFF_FFFF, 8'd0);
    submit(32'd1, 32'h8000_0001);
    submit(32'h5555_5555, 32'hAAAA_AAAA);
    submit(32'hAAAA_AAAA, 32'h5555_5555);
    submit(32'h5555_5555, 32'hAAAA_AAAB);

    run_phase(32'd1000, 8'd3, 5, 90, 400, 0);
    run_phase(32'hFFFF_FFFF, 8'd254, 1, 270, 2000, 0);
    run_phase(32'd0, 8'd0, 5, 60, 50, 1);
    run_phase(32'($urandom_range(5000, 1)), 8'd255, 6, 80, 3000, 1);
    run_phase(32'($urandom_range(100000, 100)), 8'($urandom_range(254)), 48, 180, 20000, 2);
    run_phase(32'd500, 8'd1, 48, 60, 300, 2);

    drain();
    repeat (40) @(posedge clk_i);
    $display("%0d requests under %0d limit settings, table filled and one user saturated",
             sent, settings);
    $display("%0d mismatches, %0d results never returned", mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
